// ===== rtl/pulse_beat_detector_macros.svh =====
// Assertion helpers. The enclosing module must have clock and reset in scope.
`ifndef PULSE_BEAT_DETECTOR_MACROS_SVH
`define PULSE_BEAT_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pbd_pkg.sv =====
package pbd_pkg;

   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned LEVEL_W     = 10;
   localparam int unsigned INTERVAL_W  = 16;
   localparam int unsigned RATE_W      = 8;
   localparam int unsigned MS_W        = 32;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [3:0]            STEP_RESET       = 4'd2;
   localparam logic [11:0]           REFRACTORY_RESET = 12'd250;
   localparam logic [15:0]           TIMEOUT_RESET    = 16'd2500;
   localparam logic [LEVEL_W-1:0]    LEVEL_RESTART    = 10'd512;
   localparam logic [LEVEL_W-1:0]    THRESHOLD_RESET  = 10'd525;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX        = 10'd1023;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 16'd600;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX     = 16'hFFFF;
   // three fifths of the reset interval
   localparam logic [INTERVAL_W-1:0] SETTLE_RESET     = 16'd360;
   localparam logic [INTERVAL_W-1:0] RATE_NUMERATOR   = 16'd60000;
   localparam logic [RATE_W-1:0]     RATE_MAX         = 8'd255;
   // x / 5 == (x * 52429) >> 18, exact for 16-bit x
   localparam logic [16:0]           DIV5_RECIP       = 17'd52429;
   localparam int unsigned           DIV5_SHIFT       = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_STEP = 2'd0,
      CSR_REFRACTORY  = 2'd1,
      CSR_TIMEOUT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  step_ms;
      logic [11:0] refractory_ms;
      logic [15:0] timeout_ms;
   } cfg_type;

   // one classified sample, handed from front to back
   typedef struct packed {
      logic                  beat;
      logic                  pulse;
      logic                  fill;
      logic                  form;
      logic [INTERVAL_W-1:0] interval;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/pbd_queue.sv =====
`include "pulse_beat_detector_macros.svh"

module pbd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pbd_pkg::job_type          push_job,
   input  logic                      pop,
   output pbd_pkg::job_type          head_job,
   output pbd_pkg::queue_status_type status
);
   import pbd_pkg::*;

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PBD_ASSERT_IMP(a_no_push_full, push, !status.full, "queue push while full")
   `PBD_ASSERT_IMP(a_no_pop_empty, pop, !status.empty, "queue pop while empty")

endmodule

// ===== rtl/pbd_front.sv =====
module pbd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pbd_pkg::SAMPLE_W-1:0]      req_sample,
   input  pbd_pkg::cfg_type                  cfg,
   input  pbd_pkg::queue_status_type         q_status,
   output logic                              q_push,
   output pbd_pkg::job_type                  q_job
);
   import pbd_pkg::*;

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_ELAP = 6'b000010,
      F_EVAL = 6'b000100,
      F_PUSH = 6'b001000,
      F_DIV5 = 6'b010000,
      F_MUL3 = 6'b100000
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [MS_W-1:0]       clock_ff, clock_in;
   logic [MS_W-1:0]       last_ff, last_in;
   logic [MS_W-1:0]       elapsed_ff, elapsed_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [INTERVAL_W-1:0] settle_ff, settle_in;
   logic [13:0]           fifth_ff, fifth_in;
   logic                  flag_ff, flag_in;
   logic [LEVEL_W-1:0]    peak_ff, peak_in;
   logic [LEVEL_W-1:0]    trough_ff, trough_in;
   logic [LEVEL_W-1:0]    thr_ff, thr_in;
   logic                  first_ff, first_in;
   logic                  second_ff, second_in;
   job_type               job_ff, job_in;

   logic                  accept;
   logic                  below, above, settled, beat, expired;
   logic [INTERVAL_W-1:0] interval_sat;
   logic [LEVEL_W-1:0]    peak_c, trough_c, level_c;
   logic signed [10:0]    amp_c, half_c;
   logic signed [11:0]    mid_c;
   logic                  fill_c, form_c;
   logic [32:0]           fifth_prod;

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;
   assign q_push    = (state_ff == F_PUSH) && !q_status.full;
   assign q_job     = job_ff;

   assign clock_in   = clock_ff + MS_W'(cfg.step_ms);
   assign elapsed_in = clock_ff - last_ff;

   // classification on the registered elapsed time
   assign below   = sample_ff < thr_ff;
   assign above   = sample_ff > thr_ff;
   assign settled = elapsed_ff > MS_W'(settle_ff);
   assign expired = elapsed_ff > MS_W'(cfg.timeout_ms);
   assign beat    = (elapsed_ff > MS_W'(cfg.refractory_ms)) && above && !flag_ff && settled;
   assign interval_sat = (elapsed_ff[MS_W-1:INTERVAL_W] != '0) ? INTERVAL_MAX
                                                                : elapsed_ff[INTERVAL_W-1:0];

   assign trough_c = (below && settled && (sample_ff < trough_ff)) ? sample_ff : trough_ff;
   assign peak_c   = (above && (sample_ff > peak_ff)) ? sample_ff : peak_ff;

   // mid level, halved amplitude truncated toward zero
   assign amp_c  = $signed({1'b0, peak_c}) - $signed({1'b0, trough_c});
   assign half_c = (amp_c + $signed({10'b0, amp_c[10]})) >>> 1;
   assign mid_c  = $signed({half_c[10], half_c}) + $signed({2'b00, trough_c});

   always_comb begin
      if (mid_c[11]) begin
         level_c = '0;
      end else if (mid_c[10]) begin
         level_c = LEVEL_MAX;
      end else begin
         level_c = mid_c[LEVEL_W-1:0];
      end
   end

   always_comb begin
      flag_in     = flag_ff;
      last_in     = last_ff;
      interval_in = interval_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      thr_in      = thr_ff;
      peak_in     = peak_c;
      trough_in   = trough_c;
      fill_c      = 1'b0;
      form_c      = 1'b0;
      if (beat) begin
         flag_in     = 1'b1;
         interval_in = interval_sat;
         last_in     = clock_ff;
         if (second_ff) begin
            second_in = 1'b0;
            fill_c    = 1'b1;
         end
         if (first_ff) begin
            first_in  = 1'b0;
            second_in = 1'b1;
         end else begin
            form_c = 1'b1;
         end
      end
      // the first beat ends the sample: no pulse end, no timeout
      if (!(beat && first_ff)) begin
         if (below && flag_in) begin
            flag_in   = 1'b0;
            thr_in    = level_c;
            peak_in   = level_c;
            trough_in = level_c;
         end
         if (expired) begin
            thr_in    = LEVEL_RESTART;
            peak_in   = LEVEL_RESTART;
            trough_in = LEVEL_RESTART;
            last_in   = clock_ff;
            first_in  = 1'b1;
            second_in = 1'b0;
         end
      end
   end

   assign job_in = '{beat: beat, pulse: flag_in, fill: fill_c, form: form_c,
                     interval: interval_in};

   // settle time = (interval / 5) * 3
   assign fifth_prod = 33'(interval_ff) * 33'(DIV5_RECIP);
   assign fifth_in   = 14'(fifth_prod >> DIV5_SHIFT);
   assign settle_in  = INTERVAL_W'({fifth_ff, 1'b0}) + INTERVAL_W'(fifth_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_ELAP;
            end
         end
         F_ELAP: state_in = F_EVAL;
         F_EVAL: state_in = F_PUSH;
         F_PUSH: begin
            if (!q_status.full) begin
               state_in = job_ff.beat ? F_DIV5 : F_IDLE;
            end
         end
         F_DIV5: state_in = F_MUL3;
         F_MUL3: state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
      if (state_ff == F_ELAP) begin
         elapsed_ff <= elapsed_in;
      end
      if (state_ff == F_EVAL) begin
         job_ff <= job_in;
      end
      if (state_ff == F_DIV5) begin
         fifth_ff <= fifth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         clock_ff    <= '0;
         last_ff     <= '0;
         interval_ff <= INTERVAL_RESET;
         settle_ff   <= SETTLE_RESET;
         flag_ff     <= 1'b0;
         peak_ff     <= LEVEL_RESTART;
         trough_ff   <= LEVEL_RESTART;
         thr_ff      <= THRESHOLD_RESET;
         first_ff    <= 1'b1;
         second_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            clock_ff <= clock_in;
         end
         if (state_ff == F_EVAL) begin
            last_ff     <= last_in;
            interval_ff <= interval_in;
            flag_ff     <= flag_in;
            peak_ff     <= peak_in;
            trough_ff   <= trough_in;
            thr_ff      <= thr_in;
            first_ff    <= first_in;
            second_ff   <= second_in;
         end
         if (state_ff == F_MUL3) begin
            settle_ff <= settle_in;
         end
      end
   end

endmodule

// ===== rtl/pbd_div.sv =====
`include "pulse_beat_detector_macros.svh"

module pbd_div #(
   parameter int unsigned WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] num,
   input  logic [WIDTH-1:0] den,
   output logic             done,
   output logic [WIDTH-1:0] quot
);
   localparam int unsigned CNT_W = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff;
   logic [WIDTH:0]   rem_shift;
   logic             fits;

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? WIDTH'(rem_shift - {1'b0, den_ff}) : rem_shift[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   `PBD_ASSERT_IMP(a_start_idle, start, !busy_ff, "divider started while busy")
   `PBD_ASSERT_NXT(a_done_after_last, busy_ff && (cnt_ff == '0), done_ff && !busy_ff, "divider missed done")

endmodule

// ===== rtl/pbd_back.sv =====
`include "pulse_beat_detector_macros.svh"

module pbd_back #(
   parameter int unsigned HISTORY_DEPTH = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pbd_pkg::queue_status_type          q_status,
   output logic                               q_pop,
   input  pbd_pkg::job_type                   q_job,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pbd_pkg::RATE_W-1:0]         rsp_rate_bpm,
   output logic                               rsp_beat_found,
   output logic                               rsp_pulse_high,
   output logic [pbd_pkg::INTERVAL_W-1:0]     rsp_interval_ms
);
   import pbd_pkg::*;

   localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
   localparam int unsigned SUM_W = INTERVAL_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
   // sum / HISTORY_DEPTH == (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for any SUM_W-bit sum
   localparam int unsigned      MEAN_SHIFT = SUM_W + IDX_W;
   localparam int unsigned      PROD_W     = 2 * SUM_W + 1;
   localparam logic [SUM_W:0]   MEAN_RECIP =
      (SUM_W+1)'((64'd1 << MEAN_SHIFT) / 64'(HISTORY_DEPTH) + 64'd1);

   typedef enum logic [7:0] {
      B_IDLE  = 8'b00000001,
      B_FILL  = 8'b00000010,
      B_READ  = 8'b00000100,
      B_UPD   = 8'b00001000,
      B_MEAN  = 8'b00010000,
      B_MEANW = 8'b00100000,
      B_RATEW = 8'b01000000,
      B_DONE  = 8'b10000000
   } back_state_type;

   back_state_type        state_ff, state_in;
   job_type               job_ff;
   logic [INTERVAL_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [INTERVAL_W-1:0] hist_rd_ff;
   logic                  hist_we;
   logic [IDX_W-1:0]      hist_waddr;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RATE_W-1:0]     out_rate_ff;
   logic                  out_beat_ff, out_pulse_ff;
   logic [INTERVAL_W-1:0] out_interval_ff;
   logic                  load;

   logic [PROD_W-1:0]     mean_prod;
   logic [INTERVAL_W-1:0] mean_ff;
   logic                  div_start, div_done;
   logic [INTERVAL_W-1:0] div_quot;
   logic                  mean_zero;

   assign q_pop     = (state_ff == B_IDLE) && !q_status.empty;
   assign load      = (state_ff == B_DONE) && (!out_valid_ff || rsp_ready);

   // mean by reciprocal multiply, registered in B_MEAN
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(MEAN_RECIP);
   assign mean_zero = (mean_ff == '0);

   assign div_start = (state_ff == B_MEANW) && !mean_zero;

   pbd_div #(
      .WIDTH (INTERVAL_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (RATE_NUMERATOR),
      .den   (mean_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign hist_we    = (state_ff == B_FILL) || (state_ff == B_UPD);
   assign hist_waddr = (state_ff == B_FILL) ? idx_ff : ptr_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      sum_in   = sum_ff;
      rate_in  = rate_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               if (q_job.fill) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = B_FILL;
               end else if (q_job.form) begin
                  state_in = B_READ;
               end else begin
                  state_in = B_DONE;
               end
            end
         end
         B_FILL: begin
            sum_in = sum_ff + SUM_W'(job_ff.interval);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = job_ff.form ? B_READ : B_DONE;
            end
         end
         B_READ: state_in = B_UPD;
         B_UPD: begin
            // oldest entry drops out, newest goes into its slot
            sum_in   = sum_ff - SUM_W'(hist_rd_ff) + SUM_W'(job_ff.interval);
            ptr_in   = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
            state_in = B_MEAN;
         end
         B_MEAN: state_in = B_MEANW;
         B_MEANW: begin
            if (mean_zero) begin
               rate_in  = RATE_MAX;
               state_in = B_DONE;
            end else begin
               state_in = B_RATEW;
            end
         end
         B_RATEW: begin
            if (div_done) begin
               rate_in  = (div_quot > INTERVAL_W'(RATE_MAX)) ? RATE_MAX
                                                              : div_quot[RATE_W-1:0];
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign out_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= job_ff.interval;
      end
      hist_rd_ff <= hist_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      if (state_ff == B_MEAN) begin
         mean_ff <= mean_prod[MEAN_SHIFT +: INTERVAL_W];
      end
      idx_ff <= idx_in;
      if (load) begin
         out_rate_ff     <= rate_ff;
         out_beat_ff     <= job_ff.beat;
         out_pulse_ff    <= job_ff.pulse;
         out_interval_ff <= job_ff.interval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         rate_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         rate_ff      <= rate_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rate_bpm    = out_rate_ff;
   assign rsp_beat_found  = out_beat_ff;
   assign rsp_pulse_high  = out_pulse_ff;
   assign rsp_interval_ms = out_interval_ff;

   `PBD_ASSERT_IMP(a_div_done_waited, div_done, state_ff == B_RATEW, "divider done unexpected")

endmodule

// ===== rtl/pulse_beat_detector.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// req      | in        | req_valid/req_ready  | req_sample[9:0]
// rsp      | out       | rsp_valid/rsp_ready  | rsp_rate_bpm, rsp_beat_found,
//          |           |                      | rsp_pulse_high, rsp_interval_ms
// csr      | in        | csr_valid/csr_ready  | csr_index[1:0], csr_wdata[15:0]
//
// Front takes one sample at a time, held in F_PUSH while the queue is full, and adds
// F_DIV5 and F_MUL3 when it detects a heart beat, to refresh the settle time; it runs
// ahead of the back through a 4-entry queue. Back: a sample without a new rate skips the
// divider; a rate sample waits in B_RATEW on the 16-bit restoring divider for 60000 / mean
// (the mean is one reciprocal multiply); a restart's second beat first fills every history entry.
// Reset is synchronous, active high; history RAM is not cleared (always filled first).
// rsp_ready low only holds the output register; the front keeps accepting until the
// queue fills.
module pulse_beat_detector #(
   parameter int unsigned HISTORY_DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pbd_pkg::SAMPLE_W-1:0]        req_sample,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbd_pkg::RATE_W-1:0]          rsp_rate_bpm,
   output logic                                rsp_beat_found,
   output logic                                rsp_pulse_high,
   output logic [pbd_pkg::INTERVAL_W-1:0]      rsp_interval_ms,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pbd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   queue_status_type q_status;
   logic             q_push, q_pop;
   job_type          push_job, head_job;

   // registers always take a write; index 3 is dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_STEP: cfg_in.step_ms       = csr_wdata[3:0];
            CSR_REFRACTORY:  cfg_in.refractory_ms = csr_wdata[11:0];
            CSR_TIMEOUT:     cfg_in.timeout_ms    = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{step_ms: STEP_RESET, refractory_ms: REFRACTORY_RESET,
                     timeout_ms: TIMEOUT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: clock, elapsed time, peak/trough/threshold tracking, beat decision
   pbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // classified samples waiting for the back
   pbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: interval history, mean and BPM division, output register
   pbd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .q_job           (head_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rate_bpm    (rsp_rate_bpm),
      .rsp_beat_found  (rsp_beat_found),
      .rsp_pulse_high  (rsp_pulse_high),
      .rsp_interval_ms (rsp_interval_ms)
   );

endmodule
